// ===== hdl/fpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpsm_pkg
// Shared types and constants of the flow pulse session meter: register
// indexes, result status codes, fixed-point scale factors and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fpsm_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KFACTOR = 2'd3;

	// register widths and reset values
	localparam int WIN_W  = 24;
	localparam int NEED_W = 16;
	localparam int TMO_W  = 24;
	localparam int K_W    = 10;

	localparam logic [WIN_W-1:0]  WINDOW_RST  = 24'd500000;
	localparam logic [NEED_W-1:0] NEEDED_RST  = 16'd5;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST = 24'd1000000;
	localparam logic [K_W-1:0]    KFACTOR_RST = 10'd66;

	// result fields
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 20;
	localparam int OUT_W    = 32;

	localparam logic [STATUS_W-1:0] ST_TRIGGERED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_COMPLETE  = 2'd2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

	// rate = P * 1e10 / (D * K), volume = P * 10000 / (60 * K)
	localparam int                    RATE_SCALE_W = 34;
	localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 34'd10000000000;
	localparam int                    VOL_SCALE_W  = 14;
	localparam logic [VOL_SCALE_W-1:0]  VOL_SCALE  = 14'd10000;
	localparam int                    VOL_DIV_W    = 6;
	localparam logic [VOL_DIV_W-1:0]    VOL_DIV    = 6'd60;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TOTAL_W-1:0]  pulse_total;
		logic [OUT_W-1:0]    duration_ticks;
		logic [OUT_W-1:0]    rate_ml_per_min;
		logic [OUT_W-1:0]    volume_ml;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic                arm;
		logic                first;
		logic                tick;
		logic                load_idle;
		logic                dec_idle;
		logic                zero_idle;
		logic                prep;
		logic                mul_step;
		logic                load_rate;
		logic                div_step;
		logic                load_vol;
		logic                push;
		logic [STATUS_W-1:0] push_status;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic win_hit;
		logic cnt_low;
		logic idle_le1;
		logic k_zero;
		logic mul_last;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== hdl/fpsm_rq.sv =====
// ----------------------------------------------------------------------------
// fpsm_rq
// Two-entry result queue: a head register that drives the output beat and a
// second register that takes a result while the head still waits.
// ----------------------------------------------------------------------------
module fpsm_rq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fpsm_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output fpsm_pkg::result_t  head
);

	fpsm_pkg::result_t head_q;
	fpsm_pkg::result_t tail_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign head      = head_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
				tail_q <= push_data;
			end
		end
	end

endmodule

// ===== hdl/fpsm_dp.sv =====
// ----------------------------------------------------------------------------
// fpsm_dp
// Datapath: configuration registers, pulse and tick counters, idle timer,
// a serial shift-add multiplier and a restoring divider, one bit per cycle,
// shared by the rate and volume quotients.
// ----------------------------------------------------------------------------
module fpsm_dp #(
	parameter int COUNT_BITS    = 20,
	parameter int DURATION_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pulse,
	input  fpsm_pkg::ctl_cmd_t                  cmd,
	output fpsm_pkg::dp_sts_t                   sts,
	output fpsm_pkg::result_t                   push_data
);

	localparam int NUM_W  = COUNT_BITS + fpsm_pkg::RATE_SCALE_W;
	localparam int DEN_W  = DURATION_BITS + fpsm_pkg::K_W;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int NW     = (COUNT_BITS > fpsm_pkg::NEED_W) ? COUNT_BITS : fpsm_pkg::NEED_W;
	localparam int CW     = (COUNT_BITS > fpsm_pkg::TOTAL_W) ? COUNT_BITS : fpsm_pkg::TOTAL_W;
	localparam int DW     = (DURATION_BITS > fpsm_pkg::OUT_W) ? DURATION_BITS : fpsm_pkg::OUT_W;
	localparam int VNUM_W = COUNT_BITS + fpsm_pkg::VOL_SCALE_W;
	localparam int VDEN_W = fpsm_pkg::K_W + fpsm_pkg::VOL_DIV_W;

	// configuration registers
	logic [fpsm_pkg::WIN_W-1:0]  window_q;
	logic [fpsm_pkg::NEED_W-1:0] needed_q;
	logic [fpsm_pkg::TMO_W-1:0]  timeout_q;
	logic [fpsm_pkg::K_W-1:0]    kfactor_q;

	// session state
	logic [COUNT_BITS-1:0]       cnt_q;
	logic [DURATION_BITS-1:0]    el_q;
	logic [fpsm_pkg::TMO_W-1:0]  idle_q;
	logic [COUNT_BITS-1:0]       cnt_nx;
	logic [DURATION_BITS-1:0]    el_nx;

	// arithmetic unit
	logic [COUNT_BITS-1:0]       mop_q;
	logic [NUM_W-1:0]            acc_q;
	logic [NUM_W-1:0]            num_q;
	logic [DEN_W-1:0]            den_q;
	logic [DEN_W-1:0]            rem_q;
	logic [fpsm_pkg::OUT_W-1:0]  quo_q;
	logic                        ovf_q;
	logic [fpsm_pkg::OUT_W-1:0]  rate_q;
	logic [STEP_W-1:0]           step_q;
	logic [DEN_W:0]              rem_sh;
	logic                        rem_ge;
	logic [DEN_W:0]              rem_diff;
	logic [fpsm_pkg::OUT_W-1:0]  quo_sat;

	// result formatting
	logic [CW-1:0]               tot_src;
	logic [DW-1:0]               dur_src;
	logic [fpsm_pkg::TOTAL_W-1:0] tot_sat;
	logic [fpsm_pkg::OUT_W-1:0]  dur_sat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= fpsm_pkg::WINDOW_RST;
			needed_q  <= fpsm_pkg::NEEDED_RST;
			timeout_q <= fpsm_pkg::TIMEOUT_RST;
			kfactor_q <= fpsm_pkg::KFACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpsm_pkg::REG_WINDOW:  window_q  <= cfg_data[fpsm_pkg::WIN_W-1:0];
				fpsm_pkg::REG_NEEDED:  needed_q  <= cfg_data[fpsm_pkg::NEED_W-1:0];
				fpsm_pkg::REG_TIMEOUT: timeout_q <= cfg_data[fpsm_pkg::TMO_W-1:0];
				fpsm_pkg::REG_KFACTOR: kfactor_q <= cfg_data[fpsm_pkg::K_W-1:0];
				default: ;
			endcase
		end
	end

	// saturating count and duration after this tick
	always_comb begin
		el_nx  = (el_q != '1) ? el_q + DURATION_BITS'(1) : el_q;
		cnt_nx = (pulse && (cnt_q != '1)) ? cnt_q + COUNT_BITS'(1) : cnt_q;
	end

	// count and duration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			el_q  <= '0;
		end else if (cmd.arm) begin
			cnt_q <= '0;
			el_q  <= '0;
		end else if (cmd.first) begin
			cnt_q <= COUNT_BITS'(1);
			el_q  <= '0;
		end else if (cmd.tick) begin
			cnt_q <= cnt_nx;
			el_q  <= el_nx;
		end
	end

	// idle timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
		end else if (cmd.arm || cmd.zero_idle) begin
			idle_q <= '0;
		end else if (cmd.load_idle) begin
			idle_q <= timeout_q;
		end else if (cmd.dec_idle) begin
			idle_q <= idle_q - fpsm_pkg::TMO_W'(1);
		end
	end

	// restoring divide step
	always_comb begin
		rem_sh   = {rem_q, num_q[NUM_W-1]};
		rem_ge   = (rem_sh >= {1'b0, den_q});
		rem_diff = rem_sh - {1'b0, den_q};
		quo_sat  = ovf_q ? fpsm_pkg::OUT_MAX : quo_q;
	end

	// step counter for multiply and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.prep || cmd.load_rate || cmd.load_vol) begin
			step_q <= '0;
		end else if (cmd.mul_step || cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// multiply and divide registers
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mop_q <= cnt_q;
			acc_q <= '0;
			den_q <= DEN_W'(el_q * kfactor_q);
		end else if (cmd.mul_step) begin
			mop_q <= {mop_q[COUNT_BITS-2:0], 1'b0};
			acc_q <= {acc_q[NUM_W-2:0], 1'b0}
				+ (mop_q[COUNT_BITS-1] ? NUM_W'(fpsm_pkg::RATE_SCALE) : NUM_W'(0));
		end
		if (cmd.load_rate) begin
			num_q <= acc_q;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load_vol) begin
			rate_q <= quo_sat;
			num_q  <= NUM_W'(VNUM_W'(cnt_q * fpsm_pkg::VOL_SCALE));
			den_q  <= DEN_W'(VDEN_W'(kfactor_q * fpsm_pkg::VOL_DIV));
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[fpsm_pkg::OUT_W-2:0], rem_ge};
			ovf_q <= ovf_q | quo_q[fpsm_pkg::OUT_W-1];
		end
	end

	// status to controller
	always_comb begin
		sts.win_hit  = (el_nx >= DURATION_BITS'(window_q));
		sts.cnt_low  = (NW'(cnt_nx) < NW'(needed_q));
		sts.idle_le1 = (idle_q <= fpsm_pkg::TMO_W'(1));
		sts.k_zero   = (kfactor_q == '0);
		sts.mul_last = (step_q == STEP_W'(COUNT_BITS - 1));
		sts.div_last = (step_q == STEP_W'(NUM_W - 1));
	end

	// result beat: rejection reports the values after this tick
	always_comb begin
		if (cmd.push_status == fpsm_pkg::ST_REJECTED) begin
			tot_src = CW'(cnt_nx);
			dur_src = DW'(el_nx);
		end else begin
			tot_src = CW'(cnt_q);
			dur_src = DW'(el_q);
		end
		tot_sat = (tot_src > CW'(fpsm_pkg::TOTAL_MAX)) ? fpsm_pkg::TOTAL_MAX
			: tot_src[fpsm_pkg::TOTAL_W-1:0];
		dur_sat = (dur_src > DW'(fpsm_pkg::OUT_MAX)) ? fpsm_pkg::OUT_MAX
			: dur_src[fpsm_pkg::OUT_W-1:0];
	end

	always_comb begin
		push_data        = '0;
		push_data.status = cmd.push_status;
		unique case (cmd.push_status)
			fpsm_pkg::ST_TRIGGERED: begin
				push_data.pulse_total = fpsm_pkg::TOTAL_W'(1);
			end
			fpsm_pkg::ST_REJECTED: begin
				push_data.pulse_total    = tot_sat;
				push_data.duration_ticks = dur_sat;
			end
			fpsm_pkg::ST_COMPLETE: begin
				push_data.pulse_total     = tot_sat;
				push_data.duration_ticks  = dur_sat;
				push_data.rate_ml_per_min = sts.k_zero ? fpsm_pkg::OUT_MAX : rate_q;
				push_data.volume_ml       = sts.k_zero ? fpsm_pkg::OUT_MAX : quo_sat;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/fpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpsm_ctrl
// Controller: session phase (idle, armed, startup, running) and the sequence
// that computes rate and volume at session end.
// ----------------------------------------------------------------------------
module fpsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic                pulse,
	input  logic                q_full,
	input  fpsm_pkg::dp_sts_t   sts,
	output fpsm_pkg::ctl_cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_ARMED   = 11'b000_0000_0010,
		S_STARTUP = 11'b000_0000_0100,
		S_RUNNING = 11'b000_0000_1000,
		S_PREP    = 11'b000_0001_0000,
		S_MUL     = 11'b000_0010_0000,
		S_LDR     = 11'b000_0100_0000,
		S_DIVR    = 11'b000_1000_0000,
		S_LDV     = 11'b001_0000_0000,
		S_DIVV    = 11'b010_0000_0000,
		S_PUSH    = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   phase_st;
	logic   beat;

	// items are taken only in the four session phases
	assign phase_st = (state_q == S_IDLE) || (state_q == S_ARMED)
		|| (state_q == S_STARTUP) || (state_q == S_RUNNING);
	assign in_ready = phase_st && !q_full;
	assign beat     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nx        = state_q;
		cmd             = '0;
		cmd.push_status = fpsm_pkg::ST_COMPLETE;
		if (beat && kind) begin
			cmd.arm  = 1'b1;
			state_nx = S_ARMED;
		end else begin
			unique case (state_q)
				S_IDLE: ;
				S_ARMED: begin
					if (beat && pulse) begin
						cmd.first       = 1'b1;
						cmd.push        = 1'b1;
						cmd.push_status = fpsm_pkg::ST_TRIGGERED;
						state_nx        = S_STARTUP;
					end
				end
				S_STARTUP: begin
					if (beat) begin
						cmd.tick = 1'b1;
						if (sts.win_hit) begin
							if (sts.cnt_low) begin
								cmd.push        = 1'b1;
								cmd.push_status = fpsm_pkg::ST_REJECTED;
								state_nx        = S_IDLE;
							end else begin
								cmd.load_idle = 1'b1;
								state_nx      = S_RUNNING;
							end
						end
					end
				end
				S_RUNNING: begin
					if (beat) begin
						cmd.tick = 1'b1;
						priority if (pulse) begin
							cmd.load_idle = 1'b1;
						end else if (!sts.idle_le1) begin
							cmd.dec_idle = 1'b1;
						end else begin
							cmd.zero_idle = 1'b1;
							state_nx      = S_PREP;
						end
					end
				end
				S_PREP: begin
					cmd.prep = 1'b1;
					state_nx = S_MUL;
				end
				S_MUL: begin
					if (sts.k_zero) begin
						// factor of zero: both results saturate, skip the math
						cmd.push = 1'b1;
						state_nx = S_IDLE;
					end else begin
						cmd.mul_step = 1'b1;
						if (sts.mul_last) begin
							state_nx = S_LDR;
						end
					end
				end
				S_LDR: begin
					cmd.load_rate = 1'b1;
					state_nx      = S_DIVR;
				end
				S_DIVR: begin
					cmd.div_step = 1'b1;
					if (sts.div_last) begin
						state_nx = S_LDV;
					end
				end
				S_LDV: begin
					cmd.load_vol = 1'b1;
					state_nx     = S_DIVV;
				end
				S_DIVV: begin
					cmd.div_step = 1'b1;
					if (sts.div_last) begin
						state_nx = S_PUSH;
					end
				end
				// volume quotient is complete: send the session report
				S_PUSH: begin
					cmd.push = 1'b1;
					state_nx = S_IDLE;
				end
				default: state_nx = S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/flow_pulse_session_meter.sv =====
// A triggered or rejected result is pushed with the beat that causes it and is
// driven from the head register of the result queue. Session end runs prep,
// multiply, load rate, rate divide, load volume, volume divide and push, on the
// one-bit-per-cycle multiplier and the shared restoring divider run twice.
// Throughput: one beat per cycle except in session end and while two results wait.
// Reset: arst_n clears the phase to idle, counters, timer and result queue.
// ----------------------------------------------------------------------------
// flow_pulse_session_meter
// Measures one flow session from a qualified meter pulse stream: trigger on
// the first pulse, startup check, idle timeout and rate/volume report.
// ----------------------------------------------------------------------------
module flow_pulse_session_meter #(
	parameter int COUNT_BITS    = 20,
	parameter int DURATION_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic                                pulse,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [fpsm_pkg::STATUS_W-1:0]       status,
	output logic [fpsm_pkg::TOTAL_W-1:0]        pulse_total,
	output logic [fpsm_pkg::OUT_W-1:0]          duration_ticks,
	output logic [fpsm_pkg::OUT_W-1:0]          rate_ml_per_min,
	output logic [fpsm_pkg::OUT_W-1:0]          volume_ml
);

	fpsm_pkg::ctl_cmd_t cmd;
	fpsm_pkg::dp_sts_t  sts;
	fpsm_pkg::result_t  push_data;
	fpsm_pkg::result_t  head;
	logic               q_full;

	// phase control and end-of-session sequence
	fpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.pulse    (pulse),
		.q_full   (q_full),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counters, timer, registers and arithmetic
	fpsm_dp #(
		.COUNT_BITS    (COUNT_BITS),
		.DURATION_BITS (DURATION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pulse     (pulse),
		.cmd       (cmd),
		.sts       (sts),
		.push_data (push_data)
	);

	// result queue toward the output
	fpsm_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.push_data (push_data),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign status          = head.status;
	assign pulse_total     = head.pulse_total;
	assign duration_ticks  = head.duration_ticks;
	assign rate_ml_per_min = head.rate_ml_per_min;
	assign volume_ml       = head.volume_ml;

endmodule

// ===== hdl/fpsm_chk.sv =====
// ----------------------------------------------------------------------------
// fpsm_chk
// Port-level checks of the flow pulse session meter, bound to the top level.
// ----------------------------------------------------------------------------
module fpsm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [fpsm_pkg::STATUS_W-1:0]  status,
	input logic [fpsm_pkg::TOTAL_W-1:0]   pulse_total,
	input logic [fpsm_pkg::OUT_W-1:0]     duration_ticks,
	input logic [fpsm_pkg::OUT_W-1:0]     rate_ml_per_min,
	input logic [fpsm_pkg::OUT_W-1:0]     volume_ml
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(pulse_total) && $stable(duration_ticks)
			&& $stable(rate_ml_per_min) && $stable(volume_ml))
		else $error("result beat changed while stalled");

	// trigger beat carries a single pulse and nothing else
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == fpsm_pkg::ST_TRIGGERED |->
			pulse_total == fpsm_pkg::TOTAL_W'(1) && duration_ticks == '0
			&& rate_ml_per_min == '0 && volume_ml == '0)
		else $error("trigger beat with nonzero measurement");

	// rejected session reports no rate or volume
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == fpsm_pkg::ST_REJECTED |->
			rate_ml_per_min == '0 && volume_ml == '0)
		else $error("rejected beat with rate or volume");

	// input stalls only as a result of a beat taken the cycle before
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready dropped without an accepted beat");

endmodule

bind flow_pulse_session_meter fpsm_chk u_fpsm_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.pulse_total     (pulse_total),
	.duration_ticks  (duration_ticks),
	.rate_ml_per_min (rate_ml_per_min),
	.volume_ml       (volume_ml)
);

// ===== dv/tb_flow_pulse_session_meter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flow_pulse_session_meter
// Self-checking bench for the flow pulse session meter. Tick and arm beats are
// driven on the input channel, and a session model in the bench predicts each
// triggered, rejected and complete report, including the rate and volume
// divides. Reports are checked field by field in arrival order. A short
// directed part comes first, then randomized sessions under several register
// settings, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_flow_pulse_session_meter;

	localparam logic KIND_TICK     = 1'b0;
	localparam logic KIND_ARM      = 1'b1;
	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   SETTLE_CYCLES = 150;
	localparam int   RANDOM_BEATS  = 960;

	typedef enum logic [1:0] {
		MTR_IDLE,
		MTR_ARMED,
		MTR_STARTUP,
		MTR_RUNNING
	} meter_phase_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [fpsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fpsm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic                            kind      = 1'b0;
	logic                            pulse     = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [fpsm_pkg::STATUS_W-1:0]   status;
	logic [fpsm_pkg::TOTAL_W-1:0]    pulse_total;
	logic [fpsm_pkg::OUT_W-1:0]      duration_ticks;
	logic [fpsm_pkg::OUT_W-1:0]      rate_ml_per_min;
	logic [fpsm_pkg::OUT_W-1:0]      volume_ml;

	flow_pulse_session_meter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.pulse           (pulse),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.pulse_total     (pulse_total),
		.duration_ticks  (duration_ticks),
		.rate_ml_per_min (rate_ml_per_min),
		.volume_ml       (volume_ml)
	);

	always #1 clk = ~clk;

	// session model state and register copies
	meter_phase_t                 mtr_phase     = MTR_IDLE;
	logic [fpsm_pkg::TOTAL_W-1:0] mtr_count     = '0;
	logic [fpsm_pkg::OUT_W-1:0]   mtr_elapsed   = '0;
	logic [fpsm_pkg::TMO_W-1:0]   mtr_idle_left = '0;
	logic [fpsm_pkg::WIN_W-1:0]   win_reg       = fpsm_pkg::WINDOW_RST;
	logic [fpsm_pkg::NEED_W-1:0]  need_reg      = fpsm_pkg::NEEDED_RST;
	logic [fpsm_pkg::TMO_W-1:0]   tmo_reg       = fpsm_pkg::TIMEOUT_RST;
	logic [fpsm_pkg::K_W-1:0]     kf_reg        = fpsm_pkg::KFACTOR_RST;

	fpsm_pkg::result_t session_reports[$];
	int                err_count   = 0;
	int                cycle_count = 0;
	int                live_beats  = 0;
	bit                gaps_on     = 1'b1;
	bit                stalls_on   = 1'b1;

	// advance the session model by one accepted beat, queue any report
	function automatic void meter_advance(input logic is_arm, input logic has_pulse);
		fpsm_pkg::result_t rep;
		logic [63:0]       quo;
		rep = '0;
		if (is_arm) begin
			mtr_phase     = MTR_ARMED;
			mtr_count     = '0;
			mtr_elapsed   = '0;
			mtr_idle_left = '0;
			live_beats++;
		end else if (mtr_phase == MTR_ARMED) begin
			// first pulse opens the session
			if (has_pulse) begin
				mtr_count       = fpsm_pkg::TOTAL_W'(1);
				mtr_elapsed     = '0;
				mtr_phase       = MTR_STARTUP;
				rep.status      = fpsm_pkg::ST_TRIGGERED;
				rep.pulse_total = fpsm_pkg::TOTAL_W'(1);
				session_reports.push_back(rep);
				live_beats++;
			end
		end else if (mtr_phase != MTR_IDLE) begin
			live_beats++;
			if (mtr_elapsed != fpsm_pkg::OUT_MAX)
				mtr_elapsed++;
			if (has_pulse && mtr_count != fpsm_pkg::TOTAL_MAX)
				mtr_count++;
			if (mtr_phase == MTR_STARTUP) begin
				// window end: pulse of this tick already counted
				if (mtr_elapsed >= 32'(win_reg)) begin
					if (mtr_count < 20'(need_reg)) begin
						mtr_phase          = MTR_IDLE;
						rep.status         = fpsm_pkg::ST_REJECTED;
						rep.pulse_total    = mtr_count;
						rep.duration_ticks = mtr_elapsed;
						session_reports.push_back(rep);
					end else begin
						mtr_phase     = MTR_RUNNING;
						mtr_idle_left = tmo_reg;
					end
				end
			end else if (has_pulse) begin
				mtr_idle_left = tmo_reg;
			end else if (mtr_idle_left > 1) begin
				mtr_idle_left--;
			end else begin
				// idle expiry: rate and volume with truncating divides
				mtr_idle_left      = '0;
				mtr_phase          = MTR_IDLE;
				rep.status         = fpsm_pkg::ST_COMPLETE;
				rep.pulse_total    = mtr_count;
				rep.duration_ticks = mtr_elapsed;
				if (kf_reg == '0) begin
					rep.rate_ml_per_min = fpsm_pkg::OUT_MAX;
					rep.volume_ml       = fpsm_pkg::OUT_MAX;
				end else begin
					quo = (64'(mtr_count) * 64'd10000000000) /
						(64'(mtr_elapsed) * 64'(kf_reg));
					rep.rate_ml_per_min = (quo > 64'(fpsm_pkg::OUT_MAX))
						? fpsm_pkg::OUT_MAX : quo[fpsm_pkg::OUT_W-1:0];
					quo = (64'(mtr_count) * 64'd10000) / (64'd60 * 64'(kf_reg));
					rep.volume_ml = (quo > 64'(fpsm_pkg::OUT_MAX))
						? fpsm_pkg::OUT_MAX : quo[fpsm_pkg::OUT_W-1:0];
				end
				session_reports.push_back(rep);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		err_count++;
	endtask

	// send one beat; returns at the falling edge after it is taken
	task automatic send_beat(input logic beat_kind, input logic beat_pulse);
		if (gaps_on && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= beat_kind;
		pulse    <= beat_pulse;
		do @(posedge clk); while (!in_ready);
		meter_advance(beat_kind, beat_pulse);
		@(negedge clk);
	endtask

	// hold off the sender until every report is in, then let the block settle
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (session_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [fpsm_pkg::CFG_IDX_W-1:0] idx,
		input logic [fpsm_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fpsm_pkg::REG_WINDOW:  win_reg  = data[fpsm_pkg::WIN_W-1:0];
			fpsm_pkg::REG_NEEDED:  need_reg = data[fpsm_pkg::NEED_W-1:0];
			fpsm_pkg::REG_TIMEOUT: tmo_reg  = data[fpsm_pkg::TMO_W-1:0];
			fpsm_pkg::REG_KFACTOR: kf_reg   = data[fpsm_pkg::K_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_config(input logic [fpsm_pkg::CFG_DATA_W-1:0] win,
		input logic [fpsm_pkg::CFG_DATA_W-1:0] need,
		input logic [fpsm_pkg::CFG_DATA_W-1:0] tmo,
		input logic [fpsm_pkg::CFG_DATA_W-1:0] kf);
		write_reg(fpsm_pkg::REG_WINDOW, win);
		write_reg(fpsm_pkg::REG_NEEDED, need);
		write_reg(fpsm_pkg::REG_TIMEOUT, tmo);
		write_reg(fpsm_pkg::REG_KFACTOR, kf);
	endtask

	// ticks while idle, pulse flag on arm, arm while armed and in startup
	task automatic test_idle_and_arming();
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_ARM, 1'b1);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_ARM, 1'b0);
	endtask

	// every register at its top value
	task automatic test_config_extremes();
		settle_idle();
		write_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
	endtask

	// short count at window end, pulse on the last window tick counted
	task automatic test_startup_reject();
		settle_idle();
		write_config(24'd3, 24'd3, 24'd1, 24'd1);
		send_beat(KIND_ARM, 1'b1);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b1);
	endtask

	// smallest window, no pulses needed, shortest timeout, rate saturates
	task automatic test_shortest_session();
		settle_idle();
		write_config(24'd1, 24'd0, 24'd1, 24'd1);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b0);
	endtask

	// meter factor masked to zero: rate and volume both saturate
	task automatic test_zero_factor();
		settle_idle();
		write_config(24'd1, 24'd1, 24'd1, 24'h000400);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b0);
	endtask

	// arm while running, then a pulse restarting the idle timer before expiry
	task automatic test_timeout_restart();
		settle_idle();
		write_config(24'd2, 24'hA50002, 24'd2, 24'hABC2BC);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_ARM, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b0);
	endtask

	// one well-formed session with random pulse content and some noise
	task automatic run_random_session();
		int density;
		int run_len;
		density = $urandom_range(90, 15);
		// stray ticks before arming
		repeat ($urandom_range(2, 0)) send_beat(KIND_TICK, 1'($urandom_range(1, 0)));
		send_beat(KIND_ARM, 1'($urandom_range(1, 0)));
		repeat ($urandom_range(3, 0)) send_beat(KIND_TICK, 1'b0);
		send_beat(KIND_TICK, 1'b1);
		// startup window, now and then cut short by a rearm
		while (mtr_phase == MTR_STARTUP) begin
			if ($urandom_range(199) == 0)
				send_beat(KIND_ARM, 1'b0);
			else
				send_beat(KIND_TICK, 1'($urandom_range(99) < density));
		end
		// running: pulses for a while, then silence until expiry or, now and then, a rearm
		if (mtr_phase == MTR_RUNNING) begin
			run_len = $urandom_range(24, 0);
			repeat (run_len) send_beat(KIND_TICK, 1'($urandom_range(99) < density));
			if ($urandom_range(99) < 8) begin
				send_beat(KIND_ARM, 1'b0);
			end else begin
				while (mtr_phase == MTR_RUNNING)
					send_beat(KIND_TICK, 1'b0);
			end
		end
	endtask

	task automatic test_random_sessions();
		int sess;
		int stop_at;
		int win;
		sess    = 0;
		stop_at = live_beats + RANDOM_BEATS;
		while (live_beats < stop_at) begin
			// sessions 4 to 11 run with no gaps and no stalls
			gaps_on   = !(sess >= 4 && sess < 12);
			stalls_on = gaps_on;
			if (sess % 4 == 0) begin
				settle_idle();
				win = ($urandom_range(7) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
				write_config(24'(win),
					{8'($urandom), 16'($urandom_range(win + 2, 0))},
					24'($urandom_range(16, 1)),
					{14'($urandom), 10'($urandom_range(1023, 1))});
			end else if ($urandom_range(99) < 15) begin
				settle_idle();
			end
			run_random_session();
			sess++;
		end
	endtask

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= !stalls_on || ($urandom_range(99) >= 23);
	end

	// compare each report beat with the oldest prediction
	always @(posedge clk) begin : check_reports
		fpsm_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (session_reports.size() == 0) begin
				report_mismatch("status of a report with none outstanding", status, 0);
			end else begin
				want = session_reports.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (pulse_total !== want.pulse_total)
					report_mismatch("pulse_total", pulse_total, want.pulse_total);
				if (duration_ticks !== want.duration_ticks)
					report_mismatch("duration_ticks", duration_ticks, want.duration_ticks);
				if (rate_ml_per_min !== want.rate_ml_per_min)
					report_mismatch("rate_ml_per_min", rate_ml_per_min, want.rate_ml_per_min);
				if (volume_ml !== want.volume_ml)
					report_mismatch("volume_ml", volume_ml, want.volume_ml);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_and_arming();
		test_config_extremes();
		test_startup_reject();
		test_shortest_session();
		test_zero_factor();
		test_timeout_restart();
		test_random_sessions();
		settle_idle();
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
